// File: design/rpn_pkg.sv
// rpn_pkg: shared constants for the postfix expression evaluator
// operator codes, status codes and stack sizing; no dependencies
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 3;
    localparam int ARG_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int NEED_W      = (CNT_W > ARG_W) ? CNT_W : ARG_W;
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    localparam logic [FUNC_W-1:0] FN_ADD = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SUB = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MUL = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DIV = 3'd3;
    localparam logic [FUNC_W-1:0] FN_NEG = 3'd4;
    localparam logic [FUNC_W-1:0] FN_IF  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_MAX = 3'd6;
    localparam logic [FUNC_W-1:0] FN_MIN = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIV0  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd3;

endpackage

`default_nettype wire

// File: design/rpn_ram.sv
// rpn_ram: generic single write port, single read port ram
// registered read data; no dependencies
`default_nettype none

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/rpn_alu.sv
// rpn_alu: combinational arithmetic and the signed compare used by max/min scans
// depends on rpn_pkg
`default_nettype none

module rpn_alu (
    input  wire logic [rpn_pkg::FUNC_W-1:0] func,
    input  wire logic [rpn_pkg::DATA_W-1:0] top_val,
    input  wire logic [rpn_pkg::DATA_W-1:0] sec_val,
    input  wire logic [rpn_pkg::DATA_W-1:0] thr_val,
    input  wire logic [rpn_pkg::DATA_W-1:0] acc_val,
    input  wire logic [rpn_pkg::DATA_W-1:0] scan_new,
    output logic      [rpn_pkg::DATA_W-1:0] result,
    output logic      [rpn_pkg::DATA_W-1:0] scan_out
);

    logic [rpn_pkg::DATA_W-1:0] prod;
    logic                       cond_pos;
    logic                       new_gt;
    logic                       new_lt;

    assign prod     = sec_val * top_val;
    assign cond_pos = !thr_val[rpn_pkg::DATA_W-1] && (thr_val != '0);
    assign new_gt   = $signed(scan_new) > $signed(acc_val);
    assign new_lt   = $signed(scan_new) < $signed(acc_val);

    always_comb
    begin
        case (func)
            rpn_pkg::FN_ADD: result = sec_val + top_val;
            rpn_pkg::FN_SUB: result = sec_val - top_val;
            rpn_pkg::FN_MUL: result = prod;
            rpn_pkg::FN_NEG: result = '0 - top_val;
            rpn_pkg::FN_IF:  result = cond_pos ? sec_val : top_val;
            default:         result = acc_val;
        endcase
    end

    always_comb
    begin
        if (func == rpn_pkg::FN_MAX)
        begin
            scan_out = new_gt ? scan_new : acc_val;
        end
        else
        begin
            scan_out = new_lt ? scan_new : acc_val;
        end
    end

endmodule

`default_nettype wire

// File: design/rpn_div.sv
// rpn_div: signed 32-bit divider truncating toward zero, one quotient bit per cycle
// depends on rpn_pkg
`default_nettype none

module rpn_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rpn_pkg::DATA_W-1:0] dividend,
    input  wire logic [rpn_pkg::DATA_W-1:0] divisor,
    output logic                            done,
    output logic      [rpn_pkg::DATA_W-1:0] quotient
);

    logic [rpn_pkg::DATA_W-1:0]    rem_reg, rem_next;
    logic [rpn_pkg::DATA_W-1:0]    quo_reg, quo_next;
    logic [rpn_pkg::DATA_W-1:0]    den_reg, den_next;
    logic                          neg_reg, neg_next;
    logic [rpn_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          run_reg, run_next;
    logic                          done_reg, done_next;

    logic [rpn_pkg::DATA_W-1:0] dvd_mag;
    logic [rpn_pkg::DATA_W-1:0] dvs_mag;
    logic [rpn_pkg::DATA_W:0]   rem_sh;
    logic [rpn_pkg::DATA_W:0]   diff;

    assign dvd_mag = dividend[rpn_pkg::DATA_W-1] ? ('0 - dividend) : dividend;
    assign dvs_mag = divisor[rpn_pkg::DATA_W-1]  ? ('0 - divisor)  : divisor;
    assign rem_sh  = {rem_reg, quo_reg[rpn_pkg::DATA_W-1]};
    assign diff    = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dvd_mag;
            den_next = dvs_mag;
            neg_next = dividend[rpn_pkg::DATA_W-1] ^ divisor[rpn_pkg::DATA_W-1];
            cnt_next = rpn_pkg::DIV_CNT_W'(rpn_pkg::DATA_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[rpn_pkg::DATA_W])
            begin
                rem_next = diff[rpn_pkg::DATA_W-1:0];
                quo_next = {quo_reg[rpn_pkg::DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[rpn_pkg::DATA_W-1:0];
                quo_next = {quo_reg[rpn_pkg::DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rpn_pkg::DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? ('0 - quo_reg) : quo_reg;

endmodule

`default_nettype wire

// File: design/postfix_expression_evaluator_unit.sv
// postfix_expression_evaluator_unit: top level, token sequencer and operand stack
// depends on rpn_pkg, rpn_ram, rpn_alu, rpn_div
`default_nettype none

// Evaluates a postfix expression one token per input transfer on a 64-entry
// operand stack held in a ram with registered read. The block takes one token
// at a time and holds in_stall high until that token is finished. A number
// token is pushed in the cycle it is accepted. An operator reads its operands
// from the ram one per cycle, pipelined, then executes: add, sub, mul, negate
// and IF use the alu, MAX and MIN scan their n entries, and divide waits for
// the divider, which produces one quotient bit per cycle. A token marked last
// then reads the top of stack and loads the output register. Tokens that
// arrive after an error are skipped. The result waits in its own register, so
// input tokens keep flowing while out_stall is high; only the next last token
// waits for the output register to empty. No clearing pass after reset is
// needed.
module postfix_expression_evaluator_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         is_number,
    input  wire logic [rpn_pkg::FUNC_W-1:0]   func,
    input  wire logic [rpn_pkg::DATA_W-1:0]   token_value,
    input  wire logic [rpn_pkg::ARG_W-1:0]    arg_count,
    input  wire logic                         last,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [rpn_pkg::DATA_W-1:0]   result_value,
    output logic      [rpn_pkg::STATUS_W-1:0] status
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EXEC = 6'b000100,
        S_DIV  = 6'b001000,
        S_DONE = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [rpn_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [rpn_pkg::STATUS_W-1:0]   err_reg, err_next;
    logic                           out_valid_reg, out_valid_next;
    logic [rpn_pkg::DATA_W-1:0]     res_reg, res_next;
    logic [rpn_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic [rpn_pkg::FUNC_W-1:0]     func_reg, func_next;
    logic                           last_reg, last_next;
    logic [rpn_pkg::NEED_W-1:0]     need_reg, need_next;
    logic [rpn_pkg::NEED_W-1:0]     left_reg, left_next;
    logic [rpn_pkg::NEED_W-1:0]     got_reg, got_next;
    logic [rpn_pkg::ADDR_W-1:0]     rd_addr_reg, rd_addr_next;
    logic                           pend_reg, pend_next;
    logic [rpn_pkg::DATA_W-1:0]     top_reg, top_next;
    logic [rpn_pkg::DATA_W-1:0]     sec_reg, sec_next;
    logic [rpn_pkg::DATA_W-1:0]     thr_reg, thr_next;
    logic [rpn_pkg::DATA_W-1:0]     acc_reg, acc_next;

    logic                           ram_we;
    logic [rpn_pkg::ADDR_W-1:0]     ram_waddr;
    logic [rpn_pkg::DATA_W-1:0]     ram_wdata;
    logic [rpn_pkg::ADDR_W-1:0]     ram_raddr;
    logic [rpn_pkg::DATA_W-1:0]     ram_rdata;

    logic [rpn_pkg::DATA_W-1:0]     alu_result;
    logic [rpn_pkg::DATA_W-1:0]     scan_out;
    logic                           div_start;
    logic                           div_done;
    logic [rpn_pkg::DATA_W-1:0]     div_quotient;

    logic                           accept;
    logic                           out_free;
    logic [rpn_pkg::NEED_W-1:0]     count_ext;
    logic [rpn_pkg::NEED_W-1:0]     arg_n;
    logic [rpn_pkg::NEED_W-1:0]     need_in;
    logic [rpn_pkg::NEED_W-1:0]     new_top;
    logic [rpn_pkg::CNT_W-1:0]      count_after_op;
    logic [rpn_pkg::CNT_W-1:0]      count_top;
    state_t                         state_after;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign count_ext = rpn_pkg::NEED_W'(count_reg);
    assign arg_n     = (arg_count == '0) ? rpn_pkg::NEED_W'(1)
                                         : rpn_pkg::NEED_W'(arg_count);
    assign new_top        = count_ext - need_reg;
    assign count_after_op = rpn_pkg::CNT_W'(new_top + rpn_pkg::NEED_W'(1));
    assign count_top      = count_reg - 1'b1;
    assign state_after    = last_reg ? S_DONE : S_IDLE;
    assign ram_raddr = (state_reg == S_DONE) ? count_top[rpn_pkg::ADDR_W-1:0]
                                             : rd_addr_reg;

    always_comb
    begin
        case (func)
            rpn_pkg::FN_NEG:                  need_in = rpn_pkg::NEED_W'(1);
            rpn_pkg::FN_IF:                   need_in = rpn_pkg::NEED_W'(3);
            rpn_pkg::FN_MAX, rpn_pkg::FN_MIN: need_in = arg_n;
            default:                          need_in = rpn_pkg::NEED_W'(2);
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        func_next      = func_reg;
        last_next      = last_reg;
        need_next      = need_reg;
        left_next      = left_reg;
        got_next       = got_reg;
        rd_addr_next   = rd_addr_reg;
        pend_next      = 1'b0;
        top_next       = top_reg;
        sec_next       = sec_reg;
        thr_next       = thr_reg;
        acc_next       = acc_reg;
        ram_we         = 1'b0;
        ram_waddr      = new_top[rpn_pkg::ADDR_W-1:0];
        ram_wdata      = alu_result;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    last_next  = last;
                    state_next = last ? S_DONE : S_IDLE;
                    if (err_reg == rpn_pkg::ST_OK)
                    begin
                        if (is_number)
                        begin
                            if (count_reg == rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH))
                            begin
                                err_next = rpn_pkg::ST_OVER;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[rpn_pkg::ADDR_W-1:0];
                                ram_wdata  = token_value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        else if (need_in > count_ext)
                        begin
                            err_next = rpn_pkg::ST_UNDER;
                        end
                        else
                        begin
                            need_next    = need_in;
                            left_next    = need_in;
                            got_next     = '0;
                            rd_addr_next = count_top[rpn_pkg::ADDR_W-1:0];
                            state_next   = S_READ;
                        end
                    end
                end
            end

            S_READ:
            begin
                // issue one stack read a cycle, take the data in the next cycle
                if (left_reg != '0)
                begin
                    rd_addr_next = rd_addr_reg - 1'b1;
                    left_next    = left_reg - 1'b1;
                    pend_next    = 1'b1;
                end
                if (pend_reg)
                begin
                    got_next = got_reg + 1'b1;
                    if (got_reg == '0)
                    begin
                        top_next = ram_rdata;
                        acc_next = ram_rdata;
                    end
                    else
                    begin
                        acc_next = scan_out;
                    end
                    if (got_reg == rpn_pkg::NEED_W'(1))
                    begin
                        sec_next = ram_rdata;
                    end
                    if (got_reg == rpn_pkg::NEED_W'(2))
                    begin
                        thr_next = ram_rdata;
                    end
                    if (got_reg + 1'b1 == need_reg)
                    begin
                        state_next = S_EXEC;
                    end
                    if ((got_reg == '0) && (func_reg == rpn_pkg::FN_DIV)
                        && (ram_rdata == '0))
                    begin
                        err_next   = rpn_pkg::ST_DIV0;
                        state_next = state_after;
                    end
                end
            end

            S_EXEC:
            begin
                if (func_reg == rpn_pkg::FN_DIV)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_after_op;
                    state_next = state_after;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = div_quotient;
                    count_next = count_after_op;
                    state_next = state_after;
                end
            end

            S_DONE:
            begin
                // top of stack read is in flight; wait until the output register is free
                if (out_free)
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                out_valid_next = 1'b1;
                if (err_reg != rpn_pkg::ST_OK)
                begin
                    status_next = err_reg;
                    res_next    = '0;
                end
                else if (count_reg == '0)
                begin
                    status_next = rpn_pkg::ST_UNDER;
                    res_next    = '0;
                end
                else
                begin
                    status_next = rpn_pkg::ST_OK;
                    res_next    = ram_rdata;
                end
                count_next = '0;
                err_next   = rpn_pkg::ST_OK;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            err_reg       <= rpn_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        status_reg  <= status_next;
        func_reg    <= func_next;
        last_reg    <= last_next;
        need_reg    <= need_next;
        left_reg    <= left_next;
        got_reg     <= got_next;
        rd_addr_reg <= rd_addr_next;
        top_reg     <= top_next;
        sec_reg     <= sec_next;
        thr_reg     <= thr_next;
        acc_reg     <= acc_next;
    end

    rpn_ram #(
        .WIDTH (rpn_pkg::DATA_W),
        .DEPTH (rpn_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpn_alu u_alu (
        .func     (func_reg),
        .top_val  (top_reg),
        .sec_val  (sec_reg),
        .thr_val  (thr_reg),
        .acc_val  (acc_reg),
        .scan_new (ram_rdata),
        .result   (alu_result),
        .scan_out (scan_out)
    );

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sec_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid    = out_valid_reg;
    assign result_value = res_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire
